// File: src/two_class_admission_arbiter_assert.svh
// Assertion macros for the two-class admission arbiter.
// Used by the top level; needs a clock and a synchronous active-high reset.
`ifndef TWO_CLASS_ADMISSION_ARBITER_ASSERT_SVH
`define TWO_CLASS_ADMISSION_ARBITER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TCAA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcaa: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define TCAA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcaa: next-cycle check failed");

`endif

// File: src/tcaa_pkg.sv
// Types and constants of the two-class admission arbiter.
// Used by tcaa_step and two_class_admission_arbiter; depends on nothing.
package tcaa_pkg;

  localparam int MAX_SLOTS   = 15;
  localparam int MAX_WAITERS = 255;

  localparam logic [3:0] SLOT_CAP   = (MAX_SLOTS < 15) ? 4'(MAX_SLOTS) : 4'd15;
  localparam logic [7:0] WAIT_CAP   = (MAX_WAITERS < 255) ? 8'(MAX_WAITERS) : 8'd255;
  localparam logic [3:0] STREAK_MAX = 4'd15;

  localparam logic [3:0] CAPACITY_RESET     = 4'd3;
  localparam logic [3:0] STREAK_LIMIT_RESET = 4'd5;

  localparam logic [2:0] REQ_CHECK    = 3'd0;
  localparam logic [2:0] REQ_REGISTER = 3'd1;
  localparam logic [2:0] REQ_ENTER    = 3'd2;
  localparam logic [2:0] REQ_WITHDRAW = 3'd3;
  localparam logic [2:0] REQ_EXIT     = 3'd4;
  localparam logic [2:0] REQ_STATUS   = 3'd5;

  localparam logic [1:0] CLASS_NONE   = 2'd0;
  localparam logic [1:0] CLASS_FIRST  = 2'd1;
  localparam logic [1:0] CLASS_SECOND = 2'd2;

  localparam logic CFG_CAPACITY     = 1'b0;
  localparam logic CFG_STREAK_LIMIT = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] requester_class;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic       error;
    logic [1:0] holder_class;
    logic [3:0] occupied_slots;
    logic [7:0] waiting_first;
    logic [7:0] waiting_second;
    logic       switch_forced;
    logic [3:0] streak_count;
  } rsp_t;

  typedef struct packed {
    logic [3:0] occupancy;
    logic [1:0] current_class;
    logic [3:0] streak;
    logic       forced_flag;
    logic [1:0] previous_class;
    logic [7:0] waiters_one;
    logic [7:0] waiters_two;
  } state_t;

endpackage

// File: src/tcaa_step.sv
// Admission decision and state update for one request word.
// Depends on tcaa_pkg; instantiated by two_class_admission_arbiter.
module tcaa_step (
  input  tcaa_pkg::state_t st,
  input  tcaa_pkg::req_t   req,
  input  logic [3:0]       capacity,
  input  logic [3:0]       streak_limit,
  output tcaa_pkg::state_t st_next,
  output tcaa_pkg::rsp_t   rsp_next
);

  logic       cls_ok;
  logic       is_first;
  logic [3:0] slot_lim;
  logic       may_enter;
  logic [7:0] wait_cur;
  logic [7:0] wait_new;
  logic [3:0] streak_base;
  logic       granted;
  logic       error;

  assign cls_ok   = (req.requester_class == tcaa_pkg::CLASS_FIRST) ||
                    (req.requester_class == tcaa_pkg::CLASS_SECOND);
  assign is_first = (req.requester_class == tcaa_pkg::CLASS_FIRST);
  assign slot_lim = (tcaa_pkg::SLOT_CAP < capacity) ? tcaa_pkg::SLOT_CAP : capacity;
  assign wait_cur = is_first ? st.waiters_one : st.waiters_two;

  always_comb begin
    may_enter = 1'b0;
    if (cls_ok && (st.occupancy < slot_lim)) begin
      if (st.current_class == tcaa_pkg::CLASS_NONE) begin
        if (st.forced_flag && (req.requester_class == st.previous_class)) begin
          may_enter = 1'b0;
        end else if ((st.waiters_one != 8'd0) && (st.waiters_two != 8'd0)) begin
          if (st.waiters_two > st.waiters_one) begin
            may_enter = (req.requester_class == tcaa_pkg::CLASS_SECOND);
          end else if (st.waiters_one > st.waiters_two) begin
            may_enter = is_first;
          end else begin
            may_enter = (req.requester_class != st.previous_class);
          end
        end else begin
          may_enter = 1'b1;
        end
      end else begin
        may_enter = (st.current_class == req.requester_class) && !st.forced_flag;
      end
    end
  end

  always_comb begin
    st_next     = st;
    wait_new    = wait_cur;
    streak_base = st.streak;
    granted     = 1'b0;
    error       = 1'b0;
    unique case (req.req_type)
      tcaa_pkg::REQ_CHECK: begin
        granted = may_enter;
      end
      tcaa_pkg::REQ_REGISTER: begin
        if (cls_ok && (wait_cur < tcaa_pkg::WAIT_CAP)) begin
          wait_new = wait_cur + 8'd1;
        end
      end
      tcaa_pkg::REQ_ENTER: begin
        if (may_enter) begin
          granted = 1'b1;
          if (wait_cur != 8'd0) begin
            wait_new = wait_cur - 8'd1;
          end
          if (st.current_class == tcaa_pkg::CLASS_NONE) begin
            streak_base = 4'd0;
            if ((st.previous_class != tcaa_pkg::CLASS_NONE) &&
                (st.previous_class != req.requester_class)) begin
              st_next.forced_flag = 1'b0;
            end
            st_next.current_class = req.requester_class;
          end
          st_next.streak = (streak_base < tcaa_pkg::STREAK_MAX) ?
                           streak_base + 4'd1 : streak_base;
          st_next.occupancy = st.occupancy + 4'd1;
          if (st_next.streak >= streak_limit) begin
            st_next.forced_flag = 1'b1;
          end
        end
      end
      tcaa_pkg::REQ_WITHDRAW: begin
        if (cls_ok) begin
          if (wait_cur == 8'd0) begin
            error = 1'b1;
          end else begin
            wait_new = wait_cur - 8'd1;
          end
        end
      end
      tcaa_pkg::REQ_EXIT: begin
        if (cls_ok) begin
          if (st.occupancy == 4'd0) begin
            error = 1'b1;
          end else begin
            st_next.occupancy      = st.occupancy - 4'd1;
            st_next.previous_class = req.requester_class;
            if (st.occupancy == 4'd1) begin
              st_next.current_class = tcaa_pkg::CLASS_NONE;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (cls_ok) begin
      if (is_first) begin
        st_next.waiters_one = wait_new;
      end else begin
        st_next.waiters_two = wait_new;
      end
    end
  end

  always_comb begin
    rsp_next.granted        = granted;
    rsp_next.error          = error;
    rsp_next.holder_class   = st_next.current_class;
    rsp_next.occupied_slots = st_next.occupancy;
    rsp_next.waiting_first  = st_next.waiters_one;
    rsp_next.waiting_second = st_next.waiters_two;
    rsp_next.switch_forced  = st_next.forced_flag;
    rsp_next.streak_count   = st_next.streak;
  end

endmodule

// File: src/two_class_admission_arbiter.sv
// Top level of the two-class admission arbiter: state, config and result registers.
// Depends on tcaa_pkg, tcaa_step and two_class_admission_arbiter_assert.svh.
// Each request word yields exactly one response word the cycle after it is taken.
// A request is decided combinationally against the state left by the previous
// one, so one word per cycle is sustained while rsp_ready is high; the response
// register is the only stage, and req_ready stays high while it is empty or being
// drained. Config writes are always ready and take effect on the next request.
`include "two_class_admission_arbiter_assert.svh"

module two_class_admission_arbiter (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  tcaa_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output tcaa_pkg::rsp_t  rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [3:0]      cfg_data
);

  tcaa_pkg::state_t st;
  tcaa_pkg::state_t st_next;
  tcaa_pkg::rsp_t   rsp_next;
  logic [3:0]       capacity;
  logic [3:0]       streak_limit;
  logic             req_take;

  assign req_ready = !rsp_valid || rsp_ready;
  assign req_take  = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  tcaa_step u_step (
    .st           (st),
    .req          (req),
    .capacity     (capacity),
    .streak_limit (streak_limit),
    .st_next      (st_next),
    .rsp_next     (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= tcaa_pkg::CAPACITY_RESET;
      streak_limit <= tcaa_pkg::STREAK_LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == tcaa_pkg::CFG_CAPACITY) begin
        capacity <= cfg_data;
      end else begin
        streak_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_take) begin
        st        <= st_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      rsp <= rsp_next;
    end
  end

  `TCAA_ASSERT_NEXT(a_req_gives_rsp, clk, rst, req_take, rsp_valid)
  `TCAA_ASSERT_NOW(a_holder_iff_occupied, clk, rst, rsp_valid,
    (rsp.holder_class == tcaa_pkg::CLASS_NONE) == (rsp.occupied_slots == 4'd0))
  `TCAA_ASSERT_NOW(a_grant_excludes_error, clk, rst, rsp_valid,
    !(rsp.granted && rsp.error))
  `TCAA_ASSERT_NOW(a_state_holder_iff_occupied, clk, rst, 1'b1,
    (st.current_class == tcaa_pkg::CLASS_NONE) == (st.occupancy == 4'd0))

endmodule

// File: tb/sv/testbench.sv
// Self-checking bench for two_class_admission_arbiter: request words against an admission predictor.
// Depends on tcaa_pkg and the RTL top level; needs no files or arguments.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         STALL_CYCLES = 300;
  localparam logic [1:0] CLASS_BAD    = 2'd3;
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  logic            clk;
  logic            rst;
  logic            req_valid;
  logic            req_ready;
  tcaa_pkg::req_t  req;
  logic            rsp_valid;
  logic            rsp_ready;
  tcaa_pkg::rsp_t  rsp;
  logic            cfg_valid;
  logic            cfg_ready;
  logic            cfg_index;
  logic [3:0]      cfg_data;

  logic [3:0] cap_reg   = tcaa_pkg::CAPACITY_RESET;
  logic [3:0] limit_reg = tcaa_pkg::STREAK_LIMIT_RESET;
  logic [3:0] occ       = '0;
  logic [3:0] streak    = '0;
  logic [1:0] holder    = tcaa_pkg::CLASS_NONE;
  logic [1:0] last_out  = tcaa_pkg::CLASS_NONE;
  logic       forced    = 1'b0;
  logic [7:0] wait_one  = '0;
  logic [7:0] wait_two  = '0;

  tcaa_pkg::rsp_t pending_verdicts[$];
  int   verdict_errors = 0;
  int   tx_idle_pct    = 31;
  int   rx_idle_pct    = 31;
  int   hold_requests  = 0;

  two_class_admission_arbiter u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit may_admit(logic [1:0] c);
    logic [3:0] lim;
    lim = (cap_reg < tcaa_pkg::SLOT_CAP) ? cap_reg : tcaa_pkg::SLOT_CAP;
    if (c != tcaa_pkg::CLASS_FIRST && c != tcaa_pkg::CLASS_SECOND) return 1'b0;
    if (occ >= lim) return 1'b0;
    if (holder == tcaa_pkg::CLASS_NONE) begin
      if (forced && c == last_out) return 1'b0;
      if (wait_one != 0 && wait_two != 0) begin
        if (wait_two > wait_one) return c == tcaa_pkg::CLASS_SECOND;
        if (wait_one > wait_two) return c == tcaa_pkg::CLASS_FIRST;
        return c != last_out;
      end
      return 1'b1;
    end
    if (holder == c) return !forced;
    return 1'b0;
  endfunction

  function automatic tcaa_pkg::rsp_t arbitrate(tcaa_pkg::req_t r);
    tcaa_pkg::rsp_t v;
    logic [1:0]     c;
    bit             ok;
    c  = r.requester_class;
    ok = (c == tcaa_pkg::CLASS_FIRST) || (c == tcaa_pkg::CLASS_SECOND);
    v  = '0;
    unique case (r.req_type)
      tcaa_pkg::REQ_CHECK: v.granted = may_admit(c);
      tcaa_pkg::REQ_REGISTER: begin
        if (c == tcaa_pkg::CLASS_FIRST && wait_one < tcaa_pkg::WAIT_CAP) wait_one++;
        if (c == tcaa_pkg::CLASS_SECOND && wait_two < tcaa_pkg::WAIT_CAP) wait_two++;
      end
      tcaa_pkg::REQ_ENTER: begin
        if (may_admit(c)) begin
          v.granted = 1'b1;
          if (c == tcaa_pkg::CLASS_FIRST && wait_one != 0) wait_one--;
          if (c == tcaa_pkg::CLASS_SECOND && wait_two != 0) wait_two--;
          if (holder == tcaa_pkg::CLASS_NONE) begin
            streak = '0;
            if (last_out != tcaa_pkg::CLASS_NONE && last_out != c) forced = 1'b0;
            holder = c;
          end
          if (streak < tcaa_pkg::STREAK_MAX) streak++;
          occ++;
          if (streak >= limit_reg) forced = 1'b1;
        end
      end
      tcaa_pkg::REQ_WITHDRAW: begin
        if (ok) begin
          if ((c == tcaa_pkg::CLASS_FIRST ? wait_one : wait_two) == 0) v.error = 1'b1;
          else if (c == tcaa_pkg::CLASS_FIRST) wait_one--;
          else wait_two--;
        end
      end
      tcaa_pkg::REQ_EXIT: begin
        if (ok) begin
          if (occ == 0) begin
            v.error = 1'b1;
          end else begin
            occ--;
            last_out = c;
            if (occ == 0) holder = tcaa_pkg::CLASS_NONE;
          end
        end
      end
      default: ;
    endcase
    v.holder_class   = holder;
    v.occupied_slots = occ;
    v.waiting_first  = wait_one;
    v.waiting_second = wait_two;
    v.switch_forced  = forced;
    v.streak_count   = streak;
    return v;
  endfunction

  function automatic tcaa_pkg::req_t random_request(int noise_pct);
    tcaa_pkg::req_t r;
    int             roll;
    roll = $urandom_range(99);
    if ($urandom_range(99) < noise_pct) begin
      r.req_type        = 3'($urandom_range(7));
      r.requester_class = 2'($urandom_range(3));
      return r;
    end
    r.requester_class = $urandom_range(1) ? tcaa_pkg::CLASS_SECOND : tcaa_pkg::CLASS_FIRST;
    if (holder != tcaa_pkg::CLASS_NONE && $urandom_range(99) < 70) r.requester_class = holder;
    if (roll < 20) r.req_type = tcaa_pkg::REQ_REGISTER;
    else if (roll < 50) r.req_type = tcaa_pkg::REQ_ENTER;
    else if (roll < 72) r.req_type = tcaa_pkg::REQ_EXIT;
    else if (roll < 82) r.req_type = tcaa_pkg::REQ_WITHDRAW;
    else if (roll < 92) r.req_type = tcaa_pkg::REQ_CHECK;
    else r.req_type = tcaa_pkg::REQ_STATUS;
    return r;
  endfunction

  task automatic send_word(input tcaa_pkg::req_t w);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_verdicts.push_back(arbitrate(w));
  endtask

  task automatic compare_verdict(input tcaa_pkg::rsp_t got);
    tcaa_pkg::rsp_t want;
    if (pending_verdicts.size() == 0) begin
      verdict_errors++;
      if (verdict_errors <= 10) $display("response word %h with nothing outstanding", got);
      return;
    end
    want = pending_verdicts.pop_front();
    if (got.granted !== want.granted || got.error !== want.error ||
        got.holder_class !== want.holder_class || got.occupied_slots !== want.occupied_slots ||
        got.waiting_first !== want.waiting_first ||
        got.waiting_second !== want.waiting_second ||
        got.switch_forced !== want.switch_forced || got.streak_count !== want.streak_count) begin
      verdict_errors++;
      if (verdict_errors <= 10)
        $display({"response differs: gnt %0b/%0b err %0b/%0b hold %0d/%0d occ %0d/%0d ",
                  "w1 %0d/%0d w2 %0d/%0d forced %0b/%0b streak %0d/%0d (expected/actual)"},
                 want.granted, got.granted, want.error, got.error,
                 want.holder_class, got.holder_class, want.occupied_slots, got.occupied_slots,
                 want.waiting_first, got.waiting_first, want.waiting_second, got.waiting_second,
                 want.switch_forced, got.switch_forced, want.streak_count, got.streak_count);
    end
  endtask

  // response sink: check accepted words, stall at random or for a long hold
  initial begin
    int hold_seen;
    int stall_left;
    hold_seen  = 0;
    stall_left = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) compare_verdict(rsp);
      if (hold_requests != hold_seen) begin
        hold_seen  = hold_requests;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic settle();
    req_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] cap, input logic [3:0] lim);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= tcaa_pkg::CFG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg = cap;
    cfg_index <= tcaa_pkg::CFG_STREAK_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_reg = lim;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input int noise_pct);
    for (int k = 0; k < count; k++) send_word(random_request(noise_pct));
  endtask

  task automatic test_directed();
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_STATUS, tcaa_pkg::CLASS_FIRST});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_CHECK, tcaa_pkg::CLASS_SECOND});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_EXIT, tcaa_pkg::CLASS_FIRST});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_WITHDRAW, tcaa_pkg::CLASS_SECOND});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_REGISTER, tcaa_pkg::CLASS_NONE});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_WITHDRAW, CLASS_BAD});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_EXIT, tcaa_pkg::CLASS_NONE});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_CHECK, CLASS_BAD});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_ENTER, tcaa_pkg::CLASS_NONE});
    send_word(tcaa_pkg::req_t'{REQ_SPARE_LO, tcaa_pkg::CLASS_FIRST});
    send_word(tcaa_pkg::req_t'{REQ_SPARE_HI, CLASS_BAD});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_REGISTER, tcaa_pkg::CLASS_FIRST});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_REGISTER, tcaa_pkg::CLASS_SECOND});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_REGISTER, tcaa_pkg::CLASS_SECOND});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_CHECK, tcaa_pkg::CLASS_FIRST});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_ENTER, tcaa_pkg::CLASS_SECOND});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_ENTER, tcaa_pkg::CLASS_FIRST});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_ENTER, tcaa_pkg::CLASS_SECOND});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_ENTER, tcaa_pkg::CLASS_SECOND});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_ENTER, tcaa_pkg::CLASS_SECOND});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_EXIT, tcaa_pkg::CLASS_FIRST});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_EXIT, tcaa_pkg::CLASS_SECOND});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_EXIT, tcaa_pkg::CLASS_SECOND});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_CHECK, tcaa_pkg::CLASS_FIRST});
    send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_ENTER, tcaa_pkg::CLASS_FIRST});
  endtask

  task automatic test_config_sweep();
    logic [3:0] caps [7];
    logic [3:0] lims [7];
    caps = '{4'd1, 4'd15, 4'd0, 4'd15, 4'd1, 4'd4, 4'd15};
    lims = '{4'd1, 4'd15, 4'd0, 4'd1, 4'd15, 4'd0, 4'd3};
    for (int p = 0; p < 7; p++) begin
      set_config(caps[p], lims[p]);
      tx_idle_pct = (p == 1) ? 0 : 31;
      rx_idle_pct = (p == 1) ? 0 : 31;
      run_random(130, 10);
    end
    tx_idle_pct = 31;
    rx_idle_pct = 31;
  endtask

  // fill each waiter count to its cap with unbroken registers, then mix in noise
  task automatic test_waiter_overflow();
    set_config(4'd15, 4'd15);
    for (int k = 0; k < 540; k++) begin
      if ((k % 270) >= 260 && $urandom_range(99) < 50) send_word(random_request(20));
      else send_word(tcaa_pkg::req_t'{tcaa_pkg::REQ_REGISTER,
                                      (k < 270) ? tcaa_pkg::CLASS_SECOND
                                                : tcaa_pkg::CLASS_FIRST});
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    run_random(60, 5);
    tx_idle_pct = 31;
  endtask

  task automatic test_random_tail();
    set_config(tcaa_pkg::CAPACITY_RESET, tcaa_pkg::STREAK_LIMIT_RESET);
    run_random(350, 10);
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= tcaa_pkg::CFG_CAPACITY;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_waiter_overflow();
    test_backpressure();
    test_random_tail();
    settle();
    repeat (5) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0d response words never arrived", pending_verdicts.size());
      verdict_errors += pending_verdicts.size();
    end
    if (verdict_errors == 0) begin
      $display("two_class_admission_arbiter: match");
    end else begin
      $display("two_class_admission_arbiter: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("two_class_admission_arbiter: mismatch");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/tcaa_pkg.sv
src/tcaa_step.sv
src/two_class_admission_arbiter.sv
tb/sv/testbench.sv
